FILE: design/mrpt_pkg.sv
// ----------------------------------------------------------------------------
// Miller-Rabin prime test package
// Shared constants and types for the 64-bit primality tester.
// ----------------------------------------------------------------------------
package mrpt_pkg;

    localparam int unsigned WordW = 64;

    typedef logic [WordW-1:0] t_word;

    localparam int unsigned SmallCount = 12;
    localparam int unsigned BaseCount  = 7;

    // small prime table for trial division
    function automatic logic [5:0] small_prime(input logic [3:0] idx);
        logic [5:0] p;
        begin
            case (idx)
                4'd0:    p = 6'd2;
                4'd1:    p = 6'd3;
                4'd2:    p = 6'd5;
                4'd3:    p = 6'd7;
                4'd4:    p = 6'd11;
                4'd5:    p = 6'd13;
                4'd6:    p = 6'd17;
                4'd7:    p = 6'd19;
                4'd8:    p = 6'd23;
                4'd9:    p = 6'd29;
                4'd10:   p = 6'd31;
                default: p = 6'd37;
            endcase
            return p;
        end
    endfunction

    // witness bases of the deterministic round set
    function automatic logic [30:0] witness_base(input logic [2:0] idx);
        logic [30:0] b;
        begin
            case (idx)
                3'd0:    b = 31'd2;
                3'd1:    b = 31'd325;
                3'd2:    b = 31'd9375;
                3'd3:    b = 31'd28178;
                3'd4:    b = 31'd450775;
                3'd5:    b = 31'd9780504;
                default: b = 31'd1795265022;
            endcase
            return b;
        end
    endfunction

endpackage

FILE: design/miller_rabin_prime_test_64_unit.sv
// Trial division by the small primes comes first, then per base a 31-bit
// reduction of the base and a chain of modular multiplications, all on
// the shared add/compare unit.
// One transaction at a time: the next number is taken once the result has
// been handed on. Reset (synchronous, active low) returns the sequencer to idle.
// ----------------------------------------------------------------------------
// Miller-Rabin prime test unit
// Deterministic 64-bit primality test built on one shared mod-add unit.
// ----------------------------------------------------------------------------
module miller_rabin_prime_test_64_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  mrpt_pkg::t_word   i_number,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_is_prime
);
    import mrpt_pkg::*;

    // sequencer states
    localparam logic [3:0] StIdle  = 4'd0;
    localparam logic [3:0] StTrial = 4'd1;
    localparam logic [3:0] StDiv   = 4'd2;
    localparam logic [3:0] StSplit = 4'd3;
    localparam logic [3:0] StBase  = 4'd4;
    localparam logic [3:0] StPow   = 4'd5;
    localparam logic [3:0] StMul   = 4'd6;
    localparam logic [3:0] StCheck = 4'd7;
    localparam logic [3:0] StSq    = 4'd8;
    localparam logic [3:0] StDone  = 4'd9;
    localparam logic [3:0] StRed   = 4'd10;

    // multiply purposes
    localparam logic [1:0] MulRes = 2'd0;
    localparam logic [1:0] MulB   = 2'd1;
    localparam logic [1:0] MulSq  = 2'd2;

    logic [3:0]  r_state, n_state;
    t_word       r_n, n_n;
    t_word       r_d, n_d;
    logic [5:0]  r_s, n_s;
    logic [5:0]  r_r, n_r;
    logic [3:0]  r_sp, n_sp;
    logic [2:0]  r_bi, n_bi;
    logic [6:0]  r_bit, n_bit;
    t_word       r_acc, n_acc;
    t_word       r_ma, n_ma;
    t_word       r_mb, n_mb;
    t_word       r_res, n_res;
    t_word       r_b, n_b;
    t_word       r_e, n_e;
    logic [1:0]  r_mp, n_mp;
    logic        r_add, n_add;
    logic        r_prime, n_prime;
    logic        r_ovalid, n_ovalid;

    // shared mod-add unit: (x + y) mod m, x,y < m
    t_word add_x, add_y, add_gap, add_out, mod_m;
    always_comb begin
        add_gap = mod_m - add_y;
        add_out = (add_x >= add_gap) ? (add_x - add_gap) : (add_x + add_y);
    end

    t_word nm1;
    assign nm1 = r_n - t_word'(1);

    // current witness base
    logic [30:0] base_val;
    assign base_val = witness_base(r_bi);

    always_comb begin
        mod_m = r_n;
        add_x = r_acc;
        add_y = r_add ? r_ma : r_acc;
        if (r_state == StDiv) begin
            mod_m = t_word'(small_prime(r_sp));
        end
        // bit-serial reductions add in the next dividend bit
        if ((r_state == StDiv || r_state == StRed) && r_add) begin
            add_y = t_word'(1);
        end
    end

    always_comb begin
        n_state = r_state; n_n = r_n; n_d = r_d; n_s = r_s; n_r = r_r;
        n_sp = r_sp; n_bi = r_bi; n_bit = r_bit; n_acc = r_acc;
        n_ma = r_ma; n_mb = r_mb; n_res = r_res; n_b = r_b; n_e = r_e;
        n_mp = r_mp; n_add = r_add; n_prime = r_prime; n_ovalid = r_ovalid;
        unique case (r_state)
            StIdle: begin
                if (i_valid) begin
                    n_n = i_number;
                    n_sp = '0;
                    n_state = (i_number < t_word'(2)) ? StDone : StTrial;
                    n_prime = 1'b0;
                end
            end
            // n mod p by bit-serial doubling with the shared unit
            StTrial: begin
                n_acc = '0; n_bit = 7'd64; n_add = 1'b0;
                n_state = StDiv;
            end
            StDiv: begin
                if (!r_add) begin
                    n_acc = add_out;
                    n_add = 1'b1;
                end else begin
                    n_acc = r_n[r_bit[5:0] - 6'd1] ? add_out : r_acc;
                    n_add = 1'b0;
                    n_bit = r_bit - 7'd1;
                    if (r_bit == 7'd1) begin
                        if (n_acc == '0) begin
                            n_prime = (r_n == mod_m);
                            n_state = StDone;
                        end else if (r_sp == 4'(SmallCount - 1)) begin
                            n_state = StSplit;
                            n_d = nm1;
                            n_s = '0;
                        end else begin
                            n_sp = r_sp + 4'd1;
                            n_state = StTrial;
                        end
                    end
                end
            end
            StSplit: begin
                if (!r_d[0]) begin
                    n_d = r_d >> 1;
                    n_s = r_s + 6'd1;
                end else begin
                    n_bi = '0;
                    n_state = StBase;
                end
            end
            StBase: begin
                n_acc = '0; n_bit = 7'd31; n_add = 1'b0;
                n_state = StRed;
            end
            // base mod n, bit-serially from the top base bit: a doubling, plus an add for a set bit
            StRed: begin
                n_acc = add_out;
                if (!r_add) begin
                    n_add = base_val[r_bit[4:0] - 5'd1];
                    if (!n_add) n_bit = r_bit - 7'd1;
                end else begin
                    n_add = 1'b0;
                    n_bit = r_bit - 7'd1;
                end
                if (n_bit == 7'd0) begin
                    if (n_acc == '0) begin
                        // base is a multiple of n: round skipped
                        if (r_bi == 3'(BaseCount - 1)) begin
                            n_prime = 1'b1; n_state = StDone;
                        end else begin
                            n_bi = r_bi + 3'd1; n_state = StBase;
                        end
                    end else begin
                        n_res = t_word'(1);
                        n_b = n_acc;
                        n_e = r_d;
                        n_state = StPow;
                    end
                end
            end
            StPow: begin
                if (r_e == '0) begin
                    n_r = 6'd1;
                    n_state = StCheck;
                end else if (r_e[0]) begin
                    n_ma = r_res; n_mb = r_b; n_mp = MulRes;
                    n_acc = '0; n_bit = 7'd64; n_add = 1'b0;
                    n_e[0] = 1'b0;
                    n_state = StMul;
                end else begin
                    n_ma = r_b; n_mb = r_b; n_mp = MulB;
                    n_acc = '0; n_bit = 7'd64; n_add = 1'b0;
                    n_e = r_e >> 1;
                    n_state = StMul;
                end
            end
            // double-and-add mod n, one multiplier bit at a time
            StMul: begin
                if (!r_add) begin
                    n_acc = add_out;
                    n_add = r_mb[r_bit[5:0] - 6'd1];
                    if (!n_add) n_bit = r_bit - 7'd1;
                end else begin
                    n_acc = add_out;
                    n_add = 1'b0;
                    n_bit = r_bit - 7'd1;
                end
                if (n_bit == 7'd0) begin
                    n_state = StPow;
                    unique case (r_mp)
                        MulRes: n_res = n_acc;
                        MulB:   n_b = n_acc;
                        default: begin
                            n_res = n_acc;
                            n_state = StSq;
                        end
                    endcase
                end
            end
            StCheck: begin
                if (r_res == t_word'(1) || r_res == nm1) begin
                    if (r_bi == 3'(BaseCount - 1)) begin
                        n_prime = 1'b1; n_state = StDone;
                    end else begin
                        n_bi = r_bi + 3'd1; n_state = StBase;
                    end
                end else if (r_r >= r_s) begin
                    n_prime = 1'b0; n_state = StDone;
                end else begin
                    n_ma = r_res; n_mb = r_res; n_mp = MulSq;
                    n_acc = '0; n_bit = 7'd64; n_add = 1'b0;
                    n_state = StMul;
                end
            end
            // after a squaring: only n-1 ends the round early
            StSq: begin
                n_r = r_r + 6'd1;
                if (r_res == nm1) begin
                    if (r_bi == 3'(BaseCount - 1)) begin
                        n_prime = 1'b1; n_state = StDone;
                    end else begin
                        n_bi = r_bi + 3'd1; n_state = StBase;
                    end
                end else if (r_r + 6'd1 >= r_s) begin
                    n_prime = 1'b0; n_state = StDone;
                end else begin
                    n_ma = r_res; n_mb = r_res; n_mp = MulSq;
                    n_acc = '0; n_bit = 7'd64; n_add = 1'b0;
                    n_state = StMul;
                end
            end
            StDone: begin
                n_ovalid = 1'b1;
                if (r_ovalid && i_ready) begin
                    n_ovalid = 1'b0;
                    n_state = StIdle;
                end
            end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_ovalid <= 1'b0;
            r_add <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
            r_add <= n_add;
        end
        r_n <= n_n; r_d <= n_d; r_s <= n_s; r_r <= n_r; r_sp <= n_sp;
        r_bi <= n_bi; r_bit <= n_bit; r_acc <= n_acc; r_ma <= n_ma;
        r_mb <= n_mb; r_res <= n_res; r_b <= n_b; r_e <= n_e;
        r_mp <= n_mp; r_prime <= n_prime;
    end

    assign o_ready    = (r_state == StIdle);
    assign o_valid    = r_ovalid;
    assign o_is_prime = r_prime;

endmodule

FILE: design/mrpt_checker.sv
// ----------------------------------------------------------------------------
// Miller-Rabin prime test checker
// Port-level checks on the transaction flow of the test unit.
// ----------------------------------------------------------------------------
module mrpt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_is_prime
);
    // result held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_is_prime))
        else $error("result dropped or changed under stall");

    // never ready with a pending result
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("ready while result pending");

    // an accepted number blocks the input next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken twice");

    // ready returns after result delivered
    a_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |=> !o_valid && o_ready)
        else $error("no return to idle");
endmodule

bind miller_rabin_prime_test_64_unit mrpt_checker u_mrpt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_is_prime(o_is_prime)
);

FILE: sim/tb_miller_rabin_prime_test_64_unit.sv
// ----------------------------------------------------------------------------
// Miller-Rabin prime test unit testbench
// Sends 64-bit numbers through the valid/ready input channel and checks each
// verdict against a behavioural primality predictor. A directed table covers
// the small cases, the extremes and known strong pseudoprimes; random numbers
// follow, biased towards odd values with no small factor so that most of them
// reach the witness rounds. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_miller_rabin_prime_test_64_unit;
    import mrpt_pkg::*;

    localparam int unsigned NumRandom = 78;
    localparam int unsigned SettleCyc = 70000;

    typedef struct {
        t_word num;
        logic  has_exp;
        logic  exp;
    } t_row;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  o_ready;
    t_word i_number = '0;
    logic  o_valid;
    logic  i_ready = 1'b0;
    logic  o_is_prime;

    logic  verdict_q[$];
    int    fail_cnt = 0;
    bit    idle_en = 1'b1;
    bit    sender_done = 1'b0;

    miller_rabin_prime_test_64_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_number   (i_number),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_is_prime (o_is_prime)
    );

    always #6 i_clk = ~i_clk;

    // modular arithmetic on 128-bit intermediates
    function automatic t_word mulmod(input t_word a, input t_word b, input t_word m);
        logic [127:0] p;
        p = a * b;
        p = p % m;
        return p[63:0];
    endfunction

    function automatic t_word powmod(input t_word base, input t_word e, input t_word m);
        t_word r;
        t_word b;
        r = 64'd1;
        b = base % m;
        while (e != 0) begin
            if (e[0]) r = mulmod(r, b, m);
            e = e >> 1;
            b = mulmod(b, b, m);
        end
        return r;
    endfunction

    function automatic logic is_prime_num(input t_word n);
        logic [63:0] sp[12];
        logic [63:0] wb[7];
        t_word d;
        t_word x;
        int s;
        bit comp;
        sp = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
        wb = '{2, 325, 9375, 28178, 450775, 9780504, 1795265022};
        if (n < 2) return 1'b0;
        foreach (sp[i]) if (n % sp[i] == 0) return (n == sp[i]);
        d = n - 1;
        s = 0;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        foreach (wb[i]) begin
            if (wb[i] % n == 0) continue;
            x = powmod(wb[i], d, n);
            if (x == 1 || x == n - 1) continue;
            comp = 1'b1;
            for (int r = 1; r < s; r++) begin
                x = mulmod(x, x, n);
                if (x == n - 1) begin
                    comp = 1'b0;
                    break;
                end
            end
            if (comp) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        fail_cnt++;
    endtask

    // hand one number over and queue its expected verdict
    task automatic send_number(input t_word n, input logic has_exp, input logic exp);
        logic v;
        if (idle_en && $urandom_range(99) < 37) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while (idle_en && $urandom_range(99) < 37) @(posedge i_clk);
        end
        v = is_prime_num(n);
        if (has_exp && v !== exp)
            report_mismatch($sformatf("table entry %0d says %0b", n, exp));
        i_valid  <= 1'b1;
        i_number <= n;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        verdict_q.push_back(has_exp ? exp : v);
    endtask

    // random number, mostly odd with no factor up to 37
    function automatic t_word rand_number();
        t_word n;
        int k;
        k = $urandom_range(9);
        n = {$urandom, $urandom};
        if (k < 2) return n;
        if (k == 2) return n >> $urandom_range(63);
        if (k < 5) n = n >> $urandom_range(40);
        n[0] = 1'b1;
        while (n % 3 == 0 || n % 5 == 0 || n % 7 == 0 || n % 11 == 0 || n % 13 == 0
               || n % 17 == 0 || n % 19 == 0 || n % 23 == 0 || n % 29 == 0
               || n % 31 == 0 || n % 37 == 0)
            n = n + 2;
        return n;
    endfunction

    // stimulus
    initial begin
        t_row tbl[$];
        tbl = '{
            '{64'd0, 1, 0}, '{64'd1, 1, 0}, '{64'd2, 1, 1}, '{64'd3, 1, 1},
            '{64'd4, 1, 0}, '{64'd37, 1, 1}, '{64'd74, 1, 0}, '{64'd111, 1, 0},
            '{64'd41, 1, 1}, '{64'd1369, 1, 0}, '{64'd2047, 0, 0},
            '{64'd3215031751, 0, 0}, '{64'd3825123056546413051, 0, 0},
            '{64'd18446744073709551557, 1, 1}, '{64'd18446744073709551615, 1, 0},
            '{64'd18446744073709551614, 1, 0}, '{64'd9223372036854775783, 0, 0},
            '{64'd4294967291, 0, 0}, '{64'd1795265022, 1, 0}, '{64'd9780504, 1, 0},
            '{64'd18446744073709551533, 0, 0}, '{64'd341550071728321, 0, 0}
        };
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (tbl[i]) send_number(tbl[i].num, tbl[i].has_exp, tbl[i].exp);
        i_valid <= 1'b0;
        // hold off until every queued verdict has been checked
        while (verdict_q.size() != 0) @(posedge i_clk);
        for (int i = 0; i < NumRandom; i++) begin
            idle_en = !(i >= 40 && i < 60);
            send_number(rand_number(), 1'b0, 1'b0);
        end
        i_valid <= 1'b0;
        sender_done = 1'b1;
    end

    // receiver with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= idle_en ? ($urandom_range(99) >= 37) : 1'b1;
        end
    end

    // check each verdict transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("verdict with nothing expected");
            end else begin
                logic e;
                e = verdict_q.pop_front();
                if (o_is_prime !== e)
                    report_mismatch($sformatf("is_prime %b expected %b", o_is_prime, e));
            end
        end
    end

    // end of run
    initial begin
        wait (sender_done);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (SettleCyc) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(64'd12 * 64'd80000000);
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
design/mrpt_pkg.sv
design/miller_rabin_prime_test_64_unit.sv
design/mrpt_checker.sv
sim/tb_miller_rabin_prime_test_64_unit.sv
